/* rtl/core/pesr_pkg.sv */
// ----------------------------------------------------------------------------
// pesr_pkg
// Shared types, widths and helpers of the polyline equal-spacing resampler.
// ----------------------------------------------------------------------------
package pesr_pkg;

    // fixed-point and field widths
    localparam int FRAC_BITS      = 16;
    localparam int COORD_W        = 32;
    localparam int MAG_W          = COORD_W + 1;
    localparam int SUM_W          = 2 * MAG_W;
    localparam int RAD_W          = SUM_W + 2 * FRAC_BITS;
    localparam int S_W            = RAD_W / 2;
    localparam int SPACING_W      = 31;
    localparam int SQ_W           = SPACING_W + FRAC_BITS;
    localparam int POS_W          = S_W + 1;
    localparam int REM_W          = S_W + 2;
    localparam int STEP_W         = $clog2(S_W + 1);
    localparam int MAX_POINTS_DEF = 64;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_SPACING = 3'd0;
    localparam logic [SPACING_W-1:0] SPACING_RST = 31'd1000000;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      start_new;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_of_run;
        logic                      overflow;
    } point_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SQ_LOAD,
        OP_SQ_STEP,
        OP_RT_LOAD,
        OP_RT_STEP,
        OP_DV_LOAD,
        OP_DV_STEP
    } arith_op_t;

    typedef struct packed {
        arith_op_t        op;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
    } arith_ctl_t;

    typedef struct packed {
        logic [S_W-1:0]   root;
        logic [MAG_W-1:0] quot;
        logic             rem_nz;
    } arith_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RT_LOAD,
        ST_RT,
        ST_SETUP,
        ST_CHECK,
        ST_DVX_LOAD,
        ST_DVX,
        ST_DVY_LOAD,
        ST_DVY,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EMIT_START,
        EMIT_INTERP,
        EMIT_VERTEX
    } emit_kind_t;

    // p1 +/- q, truncated toward zero when the division left a remainder
    function automatic logic signed [COORD_W-1:0] interp_fix(
        input logic signed [COORD_W-1:0] p1,
        input logic [MAG_W-1:0]          q,
        input logic                      neg,
        input logic                      nz
    );
        logic signed [MAG_W+1:0] p1_ext;
        logic signed [MAG_W+1:0] q_ext;
        logic signed [MAG_W+1:0] a;
        p1_ext = $signed({{(MAG_W + 2 - COORD_W){p1[COORD_W-1]}}, p1});
        q_ext  = $signed({2'b00, q});
        a      = neg ? (p1_ext - q_ext) : (p1_ext + q_ext);
        if (nz)
        begin
            if (!neg && (a < 0))
            begin
                a = a + 1;
            end
            else if (neg && (a > 0))
            begin
                a = a - 1;
            end
        end
        return a[COORD_W-1:0];
    endfunction

endpackage

/* rtl/core/pesr_arith.sv */
// ----------------------------------------------------------------------------
// pesr_arith
// Shared iterative unit: serial sum of squares, digit-by-digit square root
// and radix-2 multiply-divide, one step per cycle.
// ----------------------------------------------------------------------------
module pesr_arith
    import pesr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  arith_ctl_t       ctl,
    input  logic [S_W-1:0]   pos,
    input  logic [S_W-1:0]   seg,
    output arith_res_t       res
);

    logic [RAD_W-1:0] acc_reg,  acc_next;
    logic [MAG_W-1:0] sha_reg,  sha_next;
    logic [MAG_W-1:0] shb_reg,  shb_next;
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [S_W-1:0]   root_reg, root_next;
    logic [MAG_W-1:0] quot_reg, quot_next;

    logic [SUM_W-1:0] sum_step;
    logic [REM_W-1:0] rt_t;
    logic [REM_W-1:0] rt_trial;
    logic             rt_ge;
    logic [REM_W-1:0] dv_t;
    logic [REM_W-1:0] seg_ext;
    logic [REM_W-1:0] seg2_ext;
    logic [1:0]       dv_digit;
    logic [REM_W-1:0] dv_rem;

    // step datapaths
    always_comb
    begin
        sum_step = {acc_reg[SUM_W-2:0], 1'b0}
                 + (sha_reg[MAG_W-1] ? SUM_W'(ctl.mag_a) : '0)
                 + (shb_reg[MAG_W-1] ? SUM_W'(ctl.mag_b) : '0);

        rt_t     = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1:RAD_W-2]};
        rt_trial = {root_reg, 2'b01};
        rt_ge    = (rt_t >= rt_trial);

        seg_ext  = REM_W'(seg);
        seg2_ext = {1'b0, seg, 1'b0};
        dv_t     = {rem_reg[REM_W-2:0], 1'b0} + (sha_reg[MAG_W-1] ? REM_W'(pos) : '0);
        if (dv_t >= seg2_ext)
        begin
            dv_digit = 2'd2;
            dv_rem   = dv_t - seg2_ext;
        end
        else if (dv_t >= seg_ext)
        begin
            dv_digit = 2'd1;
            dv_rem   = dv_t - seg_ext;
        end
        else
        begin
            dv_digit = 2'd0;
            dv_rem   = dv_t;
        end
    end

    // operation select
    always_comb
    begin
        acc_next  = acc_reg;
        sha_next  = sha_reg;
        shb_next  = shb_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        quot_next = quot_reg;
        case (ctl.op)
            OP_SQ_LOAD:
            begin
                acc_next = '0;
                sha_next = ctl.mag_a;
                shb_next = ctl.mag_b;
            end
            OP_SQ_STEP:
            begin
                acc_next = RAD_W'(sum_step);
                sha_next = {sha_reg[MAG_W-2:0], 1'b0};
                shb_next = {shb_reg[MAG_W-2:0], 1'b0};
            end
            OP_RT_LOAD:
            begin
                acc_next  = {acc_reg[SUM_W-1:0], {(2 * FRAC_BITS){1'b0}}};
                rem_next  = '0;
                root_next = '0;
            end
            OP_RT_STEP:
            begin
                acc_next  = {acc_reg[RAD_W-3:0], 2'b00};
                rem_next  = rt_ge ? (rt_t - rt_trial) : rt_t;
                root_next = {root_reg[S_W-2:0], rt_ge};
            end
            OP_DV_LOAD:
            begin
                sha_next  = ctl.mag_a;
                rem_next  = '0;
                quot_next = '0;
            end
            OP_DV_STEP:
            begin
                sha_next  = {sha_reg[MAG_W-2:0], 1'b0};
                rem_next  = dv_rem;
                quot_next = {quot_reg[MAG_W-2:0], 1'b0} + MAG_W'(dv_digit);
            end
            default:
            begin
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            sha_reg  <= '0;
            shb_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            quot_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            sha_reg  <= sha_next;
            shb_reg  <= shb_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            quot_reg <= quot_next;
        end
    end

    assign res.root   = root_reg;
    assign res.quot   = quot_reg;
    assign res.rem_nz = (rem_reg != '0);

endmodule

/* rtl/core/polyline_equal_spacing_resampler.sv */
// ----------------------------------------------------------------------------
// polyline_equal_spacing_resampler
// Resamples polylines at a fixed arc-length spacing using one shared
// iterative arithmetic unit under a small sequencer.
// ----------------------------------------------------------------------------
// sequence: a start vertex goes to the emit state and shows its item once the output is free;
// a segment vertex runs a sum of squares, a square root and setup for its length, then
//   two 33-step divides per interpolated point (none for a point on the vertex),
//   a closing state, plus waiting on a stalled output
// one vertex at a time: vertex_stall is high from acceptance until idle again
// reset: spacing = 1000000, no previous vertex, run length zero
module polyline_equal_spacing_resampler
    import pesr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  vertex_t           vertex,
    output logic              point_valid,
    input  logic              point_stall,
    output point_t            point
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    state_t                   state_reg, state_next;
    emit_kind_t               kind_reg, kind_next;
    logic [SPACING_W-1:0]     spacing_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic [POS_W-1:0]         run_reg, run_next;
    logic                     have_prev_reg, have_prev_next;
    vertex_t                  cur_reg, cur_next;
    logic                     dx_neg_reg, dx_neg_next;
    logic                     dy_neg_reg, dy_neg_next;
    logic [MAG_W-1:0]         ax_reg, ax_next;
    logic [MAG_W-1:0]         ay_reg, ay_next;
    logic [S_W-1:0]           seg_reg, seg_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic                     at_vertex_reg, at_vertex_next;
    point_t                   point_reg, point_next;
    logic                     point_valid_reg, point_valid_next;

    arith_ctl_t               ctl;
    arith_res_t               res;

    logic                     in_acc;
    logic                     out_free;
    logic                     cfg_wr;
    logic signed [MAG_W:0]    dx_c;
    logic signed [MAG_W:0]    dy_c;
    logic [MAG_W-1:0]         ax_c;
    logic [MAG_W-1:0]         ay_c;
    logic [POS_W-1:0]         sq_ext;
    logic [POS_W-1:0]         seg_ext;
    logic [POS_W-1:0]         pos_adv;
    logic [CNT_W-1:0]         cnt_adv;
    logic                     more_pts;
    logic signed [COORD_W-1:0] py_c;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_SPACING);
    assign prdata = (paddr == REG_SPACING) ? APB_DW'(spacing_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RST;
        end
        else if (cfg_wr)
        begin
            spacing_reg <= pwdata[SPACING_W-1:0];
        end
    end

    // handshakes
    assign vertex_stall = (state_reg != ST_IDLE);
    assign in_acc       = vertex_valid && !vertex_stall;
    assign out_free     = !point_valid_reg || !point_stall;
    assign point_valid  = point_valid_reg;
    assign point        = point_reg;

    // segment deltas from the arriving vertex
    always_comb
    begin
        dx_c = $signed({vertex.vertex_x[COORD_W-1], vertex.vertex_x})
             - $signed({prev_x_reg[COORD_W-1], prev_x_reg});
        dy_c = $signed({vertex.vertex_y[COORD_W-1], vertex.vertex_y})
             - $signed({prev_y_reg[COORD_W-1], prev_y_reg});
        ax_c = dx_c[MAG_W] ? MAG_W'(-dx_c) : dx_c[MAG_W-1:0];
        ay_c = dy_c[MAG_W] ? MAG_W'(-dy_c) : dy_c[MAG_W-1:0];
    end

    // emission bookkeeping
    always_comb
    begin
        sq_ext   = POS_W'({spacing_reg, {FRAC_BITS{1'b0}}});
        seg_ext  = POS_W'(seg_reg);
        pos_adv  = pos_reg + sq_ext;
        cnt_adv  = n_reg + 1'b1;
        more_pts = (pos_adv <= seg_ext) && (cnt_adv < CNT_W'(MAX_POINTS));
        py_c     = interp_fix(prev_y_reg, res.quot, dy_neg_reg, res.rem_nz);
    end

    // shared unit operands
    always_comb
    begin
        ctl.op    = OP_IDLE;
        ctl.mag_a = ax_reg;
        ctl.mag_b = ay_reg;
        if (state_reg == ST_IDLE)
        begin
            ctl.mag_a = ax_c;
            ctl.mag_b = ay_c;
        end
        else if ((state_reg == ST_DVY_LOAD) || (state_reg == ST_DVY))
        begin
            ctl.mag_a = ay_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !vertex.start_new && have_prev_reg)
                begin
                    ctl.op = OP_SQ_LOAD;
                end
            end
            ST_SQ:       ctl.op = OP_SQ_STEP;
            ST_RT_LOAD:  ctl.op = OP_RT_LOAD;
            ST_RT:       ctl.op = OP_RT_STEP;
            ST_DVX_LOAD: ctl.op = OP_DV_LOAD;
            ST_DVX:      ctl.op = OP_DV_STEP;
            ST_DVY_LOAD: ctl.op = OP_DV_LOAD;
            ST_DVY:      ctl.op = OP_DV_STEP;
            default:     ctl.op = OP_IDLE;
        endcase
    end

    pesr_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pos   (pos_reg[S_W-1:0]),
        .seg   (seg_reg),
        .res   (res)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        run_next         = run_reg;
        have_prev_next   = have_prev_reg;
        cur_next         = cur_reg;
        dx_neg_next      = dx_neg_reg;
        dy_neg_next      = dy_neg_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        seg_next         = seg_reg;
        pos_next         = pos_reg;
        n_next           = n_reg;
        step_next        = step_reg;
        px_next          = px_reg;
        at_vertex_next   = at_vertex_reg;
        point_next       = point_reg;
        point_valid_next = point_valid_reg && point_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cur_next    = vertex;
                    dx_neg_next = dx_c[MAG_W];
                    dy_neg_next = dy_c[MAG_W];
                    ax_next     = ax_c;
                    ay_next     = ay_c;
                    step_next   = '0;
                    if (vertex.start_new || !have_prev_reg)
                    begin
                        kind_next  = EMIT_START;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = ST_RT_LOAD;
                end
            end
            ST_RT_LOAD:
            begin
                step_next  = '0;
                state_next = ST_RT;
            end
            ST_RT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(S_W - 1))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                seg_next       = res.root;
                pos_next       = (run_reg < sq_ext) ? (sq_ext - run_reg) : '0;
                n_next         = '0;
                at_vertex_next = 1'b0;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((pos_reg < seg_ext) && (n_reg < CNT_W'(MAX_POINTS)))
                begin
                    state_next = ST_DVX_LOAD;
                end
                else if ((pos_reg == seg_ext) && (n_reg < CNT_W'(MAX_POINTS)))
                begin
                    kind_next  = EMIT_VERTEX;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DVX_LOAD:
            begin
                step_next  = '0;
                state_next = ST_DVX;
            end
            ST_DVX:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = ST_DVY_LOAD;
                end
            end
            ST_DVY_LOAD:
            begin
                px_next    = interp_fix(prev_x_reg, res.quot, dx_neg_reg, res.rem_nz);
                step_next  = '0;
                state_next = ST_DVY;
            end
            ST_DVY:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    kind_next  = EMIT_INTERP;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    point_valid_next = 1'b1;
                    case (kind_reg)
                        EMIT_START:
                        begin
                            point_next.point_x     = cur_reg.vertex_x;
                            point_next.point_y     = cur_reg.vertex_y;
                            point_next.last_of_run = 1'b1;
                            point_next.overflow    = 1'b0;
                            prev_x_next            = cur_reg.vertex_x;
                            prev_y_next            = cur_reg.vertex_y;
                            run_next               = '0;
                            have_prev_next         = 1'b1;
                            state_next             = ST_IDLE;
                        end
                        EMIT_VERTEX:
                        begin
                            point_next.point_x     = cur_reg.vertex_x;
                            point_next.point_y     = cur_reg.vertex_y;
                            point_next.last_of_run = 1'b1;
                            point_next.overflow    = 1'b0;
                            at_vertex_next         = 1'b1;
                            n_next                 = cnt_adv;
                            state_next             = ST_FINISH;
                        end
                        default:
                        begin
                            // interpolated point, flags look one position ahead
                            point_next.point_x     = px_reg;
                            point_next.point_y     = py_c;
                            point_next.last_of_run = !more_pts;
                            point_next.overflow    = (pos_adv <= seg_ext)
                                                   && (cnt_adv == CNT_W'(MAX_POINTS));
                            n_next                 = cnt_adv;
                            pos_next               = pos_adv;
                            state_next             = more_pts ? ST_CHECK : ST_FINISH;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                run_next    = at_vertex_reg ? '0 : (seg_ext + sq_ext - pos_reg);
                prev_x_next = cur_reg.vertex_x;
                prev_y_next = cur_reg.vertex_y;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= EMIT_START;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            run_reg         <= '0;
            have_prev_reg   <= 1'b0;
            n_reg           <= '0;
            step_reg        <= '0;
            at_vertex_reg   <= 1'b0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            run_reg         <= run_next;
            have_prev_reg   <= have_prev_next;
            n_reg           <= n_next;
            step_reg        <= step_next;
            at_vertex_reg   <= at_vertex_next;
            point_valid_reg <= point_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        dx_neg_reg <= dx_neg_next;
        dy_neg_reg <= dy_neg_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        seg_reg    <= seg_next;
        pos_reg    <= pos_next;
        px_reg     <= px_next;
        point_reg  <= point_next;
    end

endmodule

/* rtl/core/pesr_checker.sv */
// ----------------------------------------------------------------------------
// pesr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module pesr_checker
    import pesr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pready,
    input logic              vertex_valid,
    input logic              vertex_stall,
    input logic              point_valid,
    input logic              point_stall,
    input point_t            point
);

    // configuration port never waits
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // a stalled item stays offered
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid)
        else $error("point item dropped while stalled");

    // an accepted vertex makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_stall |=> vertex_stall)
        else $error("vertex taken while previous one still in work");

    // overflow only rides on the final item of a run
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> (!point.overflow || point.last_of_run))
        else $error("overflow on a non-final item");

    // more items of a run pending keeps the input closed
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && !point.last_of_run |-> vertex_stall)
        else $error("input open mid run");

endmodule

bind polyline_equal_spacing_resampler pesr_checker u_pesr_checker (.*);
